// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the clocked concurrent checks of the converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// An implication checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Word formats, fixed-point constants and stage bundles of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int FX_W        = FRAC_BITS + 1;
	localparam int SCALE_W     = FRAC_BITS + 3;
	localparam int MUL_W       = 2 * FX_W;
	localparam int HUE_SECTORS = 6;

	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef logic [FX_W-1:0]      fx_t;

	localparam fx_t FX_ONE = fx_t'(1) << FRAC_BITS;

	typedef struct packed {
		frac_t hue;
		fx_t   saturation;
		fx_t   brightness;
	} hsv_t;

	typedef struct packed {
		fx_t  red;
		fx_t  green;
		fx_t  blue;
		logic range_error;
	} rgb_t;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	// Decoded color after the first stage.
	typedef struct packed {
		sector_t sector;
		logic    err;
		fx_t     s;
		fx_t     v;
		fx_t     om_s;
		frac_t   f;
		fx_t     om_f;
	} dec_t;

	// Final channel candidates after the product stages.
	typedef struct packed {
		sector_t sector;
		logic    err;
		fx_t     v;
		fx_t     p;
		fx_t     q;
		fx_t     t;
	} chroma_t;

endpackage

`default_nettype wire

// ===== rtl/hsv2rgb_decode.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_decode
// Stage one: range check, hue sector and fraction, complements of s and f.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_decode (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               hsv_valid,
	input  wire hsv2rgb_pkg::hsv_t  hsv,
	output logic                    valid_s1,
	output hsv2rgb_pkg::dec_t       dec_s1
);
	import hsv2rgb_pkg::*;

	logic [SCALE_W-1:0] scaled;
	dec_t               dec;

	always_comb begin
		scaled     = SCALE_W'(hsv.hue) * SCALE_W'(HUE_SECTORS);
		dec.sector = sector_t'(scaled[SCALE_W-1:FRAC_BITS]);
		dec.err    = (hsv.saturation > FX_ONE) || (hsv.brightness > FX_ONE);
		dec.s      = hsv.saturation;
		dec.v      = hsv.brightness;
		dec.om_s   = FX_ONE - hsv.saturation;
		dec.f      = scaled[FRAC_BITS-1:0];
		dec.om_f   = FX_ONE - {1'b0, scaled[FRAC_BITS-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= hsv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_product.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_product
// Stages two and three: the truncated products that form p, q and t.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_product (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               valid_s1,
	input  wire hsv2rgb_pkg::dec_t  dec_s1,
	output logic                    valid_s3,
	output hsv2rgb_pkg::chroma_t    chroma_s3
);
	import hsv2rgb_pkg::*;

	logic [MUL_W-1:0] sf_full, sf1_full, p_full, q_full, t_full;
	logic             valid_s2;
	sector_t          sector_s2;
	logic             err_s2;
	fx_t              v_s2, p_s2, sf_s2, sf1_s2;

	// Inner products s*f and s*(1-f), and p = v*(1-s).
	always_comb begin
		sf_full  = MUL_W'(dec_s1.s) * MUL_W'(dec_s1.f);
		sf1_full = MUL_W'(dec_s1.s) * MUL_W'(dec_s1.om_f);
		p_full   = MUL_W'(dec_s1.v) * MUL_W'(dec_s1.om_s);
	end

	// Outer products q = v*(1-s*f) and t = v*(1-s*(1-f)).
	always_comb begin
		q_full = MUL_W'(v_s2) * MUL_W'(FX_ONE - sf_s2);
		t_full = MUL_W'(v_s2) * MUL_W'(FX_ONE - sf1_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s2        <= dec_s1.sector;
			err_s2           <= dec_s1.err;
			v_s2             <= dec_s1.v;
			p_s2             <= p_full[FRAC_BITS +: FX_W];
			sf_s2            <= sf_full[FRAC_BITS +: FX_W];
			sf1_s2           <= sf1_full[FRAC_BITS +: FX_W];
			chroma_s3.sector <= sector_s2;
			chroma_s3.err    <= err_s2;
			chroma_s3.v      <= v_s2;
			chroma_s3.p      <= p_s2;
			chroma_s3.q      <= q_full[FRAC_BITS +: FX_W];
			chroma_s3.t      <= t_full[FRAC_BITS +: FX_W];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_select.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_select
// Stage four: sector routing of v, p, q and t into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_select (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 valid_s3,
	input  wire hsv2rgb_pkg::chroma_t chroma_s3,
	output logic                      valid_s4,
	output hsv2rgb_pkg::rgb_t         rgb_s4
);
	import hsv2rgb_pkg::*;

	rgb_t rgb;

	always_comb begin
		case (chroma_s3.sector)
			SEC_0: begin
				rgb.red = chroma_s3.v; rgb.green = chroma_s3.t; rgb.blue = chroma_s3.p;
			end
			SEC_1: begin
				rgb.red = chroma_s3.q; rgb.green = chroma_s3.v; rgb.blue = chroma_s3.p;
			end
			SEC_2: begin
				rgb.red = chroma_s3.p; rgb.green = chroma_s3.v; rgb.blue = chroma_s3.t;
			end
			SEC_3: begin
				rgb.red = chroma_s3.p; rgb.green = chroma_s3.q; rgb.blue = chroma_s3.v;
			end
			SEC_4: begin
				rgb.red = chroma_s3.t; rgb.green = chroma_s3.p; rgb.blue = chroma_s3.v;
			end
			default: begin
				rgb.red = chroma_s3.v; rgb.green = chroma_s3.p; rgb.blue = chroma_s3.q;
			end
		endcase
		rgb.range_error = chroma_s3.err;
		if (chroma_s3.err) begin
			rgb.red   = '0;
			rgb.green = '0;
			rgb.blue  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s4 <= rgb;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined six-sector HSV to RGB color conversion in unsigned Q1.16 fixed point.
// ----------------------------------------------------------------------------
// The block converts one HSV word per clock into one RGB word while the
// receiver does not stall. Input words arrive on the hsv channel and are
// accepted at a rising edge at which hsv_valid is high and hsv_stall is low;
// results leave on the rgb channel under the same rule with rgb_valid and
// rgb_stall. Each word passes four register stages: a decode stage, two
// multiplier stages and a sector select stage. The edge that accepts a word
// loads the decode stage; the word then moves through the multiplier stages
// and the select stage to the rgb channel. The multiplier chain v*(1-s*f)
// sets this depth, as each product is registered before the next one uses
// it. Throughput is one word per clock while the receiver does not stall.
// When the receiver stalls while a result is shown, the whole pipeline
// holds, hsv_stall rises in the same cycle, and no word is lost or repeated.
// An empty output register never holds the pipeline.
// Saturation or brightness above 1.0 gives range_error high and zero colors.
// Reset clears all stage valid bits, so the block starts empty and ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hsv_to_rgb_converter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hsv_valid,
	output logic                   hsv_stall,
	input  wire hsv2rgb_pkg::hsv_t hsv,
	output logic                   rgb_valid,
	input  wire logic              rgb_stall,
	output hsv2rgb_pkg::rgb_t      rgb
);
	import hsv2rgb_pkg::*;

	// The pipeline moves as one whenever the output word is taken or absent.
	logic    adv;
	logic    valid_s1;
	logic    valid_s3;
	dec_t    dec_s1;
	chroma_t chroma_s3;

	assign adv       = !(rgb_valid && rgb_stall);
	assign hsv_stall = !adv;

	hsv2rgb_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.hsv_valid (hsv_valid),
		.hsv       (hsv),
		.valid_s1  (valid_s1),
		.dec_s1    (dec_s1)
	);

	hsv2rgb_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.dec_s1    (dec_s1),
		.valid_s3  (valid_s3),
		.chroma_s3 (chroma_s3)
	);

	hsv2rgb_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_s3  (valid_s3),
		.chroma_s3 (chroma_s3),
		.valid_s4  (rgb_valid),
		.rgb_s4    (rgb)
	);

	// An out-of-range word must come out with all color channels cleared.
	`ASSERT_IMP(a_err_zero, clk, arst_n, rgb_valid && rgb.range_error,
		rgb.red == '0 && rgb.green == '0 && rgb.blue == '0)

	// A valid in-range result never exceeds 1.0 in any channel.
	`ASSERT_IMP(a_chan_max, clk, arst_n, rgb_valid && !rgb.range_error,
		rgb.red <= FX_ONE && rgb.green <= FX_ONE && rgb.blue <= FX_ONE)

	// A word accepted and then advanced through the multiplier and select stages reaches the output.
	`ASSERT_CLK(a_latency, clk, arst_n,
		(hsv_valid && !hsv_stall) ##1 adv ##1 adv ##1 adv |=> rgb_valid)

endmodule

`default_nettype wire
